FILE: hdl/swt_pkg.sv
// Shared types, constants and codes for the sleep/wake-up timer table.
`timescale 1ns / 1ps

package swt_pkg;

    localparam int TABLE_DEPTH_DEF = 16;
    localparam int ID_BITS_DEF     = 16;
    localparam int TICK_W          = 63;
    localparam int STATUS_W        = 2;

    localparam logic [TICK_W-1:0] TICK_MAX = '1;

    // input word kinds
    localparam logic MODE_TICK = 1'b1;

    typedef enum logic [STATUS_W-1:0] {
        STATUS_ACCEPTED = 2'd0,
        STATUS_FULL     = 2'd1,
        STATUS_WOKEN    = 2'd2,
        STATUS_NONE     = 2'd3
    } swt_status_t;

    typedef enum logic [2:0] {
        ST_IDLE,
        ST_SLEEP,
        ST_SCAN,
        ST_FINISH,
        ST_EMIT
    } swt_state_t;

    // controller -> datapath
    typedef struct packed {
        logic accept;     // input port ready
        logic sleep_do;   // append entry (if room) and load sleep result
        logic scan_step;  // process one table entry
        logic finish;     // commit compacted entry count
        logic load_none;  // load "nothing woken" result
        logic emit_step;  // load one woken result
    } swt_cmd_t;

    // datapath -> controller
    typedef struct packed {
        logic in_valid;
        logic in_tick;
        logic scan_done;
        logic none_woken;
        logic emit_last;
        logic out_free;
    } swt_stat_t;

endpackage

FILE: hdl/swt_in_if.sv
// Input channel: sleep requests and timer ticks.
`timescale 1ns / 1ps

interface swt_in_if #(
    parameter int ID_W = swt_pkg::ID_BITS_DEF
);
    logic                      valid;
    logic                      ready;
    logic                      mode;
    logic [ID_W-1:0]           thread_id;
    logic [swt_pkg::TICK_W-1:0] tick_value;

    modport source (output valid, mode, thread_id, tick_value, input ready);
    modport sink   (input valid, mode, thread_id, tick_value, output ready);
endinterface

FILE: hdl/swt_out_if.sv
// Output channel: status words and woken thread IDs.
`timescale 1ns / 1ps

interface swt_out_if #(
    parameter int ID_W = swt_pkg::ID_BITS_DEF
);
    logic                         valid;
    logic                         ready;
    logic [swt_pkg::STATUS_W-1:0] status;
    logic [ID_W-1:0]              woken_id;
    logic [swt_pkg::TICK_W-1:0]   next_wakeup;
    logic                         last;

    modport source (output valid, status, woken_id, next_wakeup, last, input ready);
    modport sink   (input valid, status, woken_id, next_wakeup, last, output ready);
endinterface

FILE: hdl/sleep_wakeup_timer_table.sv
// Top level of the sleep/wake-up timer table.
`timescale 1ns / 1ps

// Alarm-clock sleep queue. Words arrive on "item" (valid/ready): mode 0 is a
// sleep request (thread_id, wake tick), mode 1 is a timer tick (current tick).
// Results leave on "result" (valid/ready) with status, woken_id, next_wakeup
// and last; last marks the final word caused by one input word.
// Sleep request: one word, loaded once the output register is free. A full
// table drops the request and reports status FULL with the wake-up unchanged.
// Timer tick: the table is scanned one entry per cycle through a single RAM
// read port. The scan is followed by the count commit, which also loads a
// NONE word if nothing woke, else by woken-buffer reads. Woken IDs are sent
// one per cycle while the receiver takes them, in insertion order, all
// carrying the final earliest wake-up.
// One input word is worked at a time; the next is accepted as soon as the
// last result sits in the output register, even if it is not yet taken.
// A stalled receiver holds the output register and pauses the sequencer.
// Reset empties the table and sets the earliest wake-up to all ones; table
// contents need no clearing since only entries below the count are read.
module sleep_wakeup_timer_table #(
    parameter int TABLE_DEPTH = swt_pkg::TABLE_DEPTH_DEF,
    parameter int ID_BITS     = swt_pkg::ID_BITS_DEF
) (
    input  logic      clk,
    input  logic      rst_n,
    swt_in_if.sink    item,
    swt_out_if.source result
);

    swt_pkg::swt_cmd_t  cmd;
    swt_pkg::swt_stat_t stat;

    swt_ctrl u_ctrl (
        .clk   (clk),
        .rst_n (rst_n),
        .stat  (stat),
        .cmd   (cmd)
    );

    swt_dp #(
        .DEPTH (TABLE_DEPTH),
        .ID_W  (ID_BITS)
    ) u_dp (
        .clk    (clk),
        .rst_n  (rst_n),
        .item   (item),
        .result (result),
        .cmd    (cmd),
        .stat   (stat)
    );

endmodule

FILE: hdl/swt_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps

module swt_ram #(
    parameter int WIDTH = 8,
    parameter int DEPTH = 16,
    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
    input  logic             clk,
    input  logic             we,
    input  logic [AW-1:0]    waddr,
    input  logic [WIDTH-1:0] wdata,
    input  logic [AW-1:0]    raddr,
    output logic [WIDTH-1:0] rdata
);

    logic [WIDTH-1:0] mem_reg [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem_reg[waddr] <= wdata;
        end
        rdata_reg <= mem_reg[raddr];
    end

    assign rdata = rdata_reg;

endmodule

FILE: hdl/swt_ctrl.sv
// Sequencer for sleep, scan, compaction and result emission.
`timescale 1ns / 1ps

module swt_ctrl (
    input  logic               clk,
    input  logic               rst_n,
    input  swt_pkg::swt_stat_t stat,
    output swt_pkg::swt_cmd_t  cmd
);

    swt_pkg::swt_state_t state_reg, state_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= swt_pkg::ST_IDLE;
        end
        else
        begin
            state_reg <= state_next;
        end
    end

    always_comb
    begin
        state_next = state_reg;
        case (state_reg)
            swt_pkg::ST_IDLE:
            begin
                if (stat.in_valid)
                begin
                    state_next = stat.in_tick ? swt_pkg::ST_SCAN : swt_pkg::ST_SLEEP;
                end
            end
            swt_pkg::ST_SLEEP:
            begin
                if (stat.out_free)
                begin
                    state_next = swt_pkg::ST_IDLE;
                end
            end
            swt_pkg::ST_SCAN:
            begin
                if (stat.scan_done)
                begin
                    state_next = swt_pkg::ST_FINISH;
                end
            end
            swt_pkg::ST_FINISH:
            begin
                if (!stat.none_woken)
                begin
                    state_next = swt_pkg::ST_EMIT;
                end
                else if (stat.out_free)
                begin
                    state_next = swt_pkg::ST_IDLE;
                end
            end
            swt_pkg::ST_EMIT:
            begin
                if (stat.out_free && stat.emit_last)
                begin
                    state_next = swt_pkg::ST_IDLE;
                end
            end
            default:
            begin
                state_next = swt_pkg::ST_IDLE;
            end
        endcase
    end

    always_comb
    begin
        cmd = '0;
        case (state_reg)
            swt_pkg::ST_IDLE:
            begin
                cmd.accept = 1'b1;
            end
            swt_pkg::ST_SLEEP:
            begin
                cmd.sleep_do = stat.out_free;
            end
            swt_pkg::ST_SCAN:
            begin
                cmd.scan_step = !stat.scan_done;
            end
            swt_pkg::ST_FINISH:
            begin
                cmd.finish    = 1'b1;
                cmd.load_none = stat.none_woken && stat.out_free;
            end
            swt_pkg::ST_EMIT:
            begin
                cmd.emit_step = stat.out_free;
            end
            default:
            begin
                cmd = '0;
            end
        endcase
    end

endmodule

FILE: hdl/swt_dp.sv
// Datapath: entry table, woken-ID buffer, counters and output register.
`timescale 1ns / 1ps

module swt_dp #(
    parameter int DEPTH = swt_pkg::TABLE_DEPTH_DEF,
    parameter int ID_W  = swt_pkg::ID_BITS_DEF
) (
    input  logic               clk,
    input  logic               rst_n,
    swt_in_if.sink             item,
    swt_out_if.source          result,
    input  swt_pkg::swt_cmd_t  cmd,
    output swt_pkg::swt_stat_t stat
);

    localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CW = $clog2(DEPTH + 1);
    localparam int TW = swt_pkg::TICK_W;
    localparam int EW = TW + ID_W;
    localparam logic [CW-1:0] CNT_FULL = CW'(DEPTH);
    localparam logic [CW-1:0] CNT_ONE  = CW'(1);

    // captured input word
    logic            mode_reg;
    logic [ID_W-1:0] id_reg;
    logic [TW-1:0]   tick_reg;

    logic [CW-1:0] count_reg, count_next;
    logic [TW-1:0] earliest_reg, earliest_next;
    logic [CW-1:0] scan_reg, scan_next;
    logic [CW-1:0] keep_reg, keep_next;
    logic [CW-1:0] wcnt_reg, wcnt_next;
    logic [CW-1:0] ptr_reg, ptr_next;
    logic          out_valid_reg, out_valid_next;

    logic [swt_pkg::STATUS_W-1:0] out_status_reg;
    logic [ID_W-1:0]              out_id_reg;
    logic [TW-1:0]                out_next_reg;
    logic                         out_last_reg;

    logic            capture;
    logic            full;
    logic            out_free;
    logic            wake_hit;
    logic            emit_last;
    logic [TW-1:0]   sleep_min;
    logic [TW-1:0]   entry_tick;
    logic [ID_W-1:0] entry_id;

    logic            tbl_we;
    logic [AW-1:0]   tbl_waddr;
    logic [EW-1:0]   tbl_wdata;
    logic [AW-1:0]   tbl_raddr;
    logic [EW-1:0]   tbl_rdata;

    logic            wk_we;
    logic [AW-1:0]   wk_raddr;
    logic [ID_W-1:0] wk_rdata;

    assign item.ready = cmd.accept;
    assign capture    = cmd.accept && item.valid;

    assign full       = (count_reg == CNT_FULL);
    assign out_free   = !out_valid_reg || result.ready;
    assign entry_tick = tbl_rdata[EW-1:ID_W];
    assign entry_id   = tbl_rdata[ID_W-1:0];
    assign wake_hit   = (tick_reg >= entry_tick);
    assign emit_last  = (CW'(ptr_reg + CNT_ONE) == wcnt_reg);
    assign sleep_min  = (!full && (tick_reg < earliest_reg)) ? tick_reg : earliest_reg;

    assign stat.in_valid   = item.valid;
    assign stat.in_tick    = (item.mode == swt_pkg::MODE_TICK);
    assign stat.scan_done  = (scan_reg == count_reg);
    assign stat.none_woken = (wcnt_reg == '0);
    assign stat.emit_last  = emit_last;
    assign stat.out_free   = out_free;

    always_comb
    begin
        count_next    = count_reg;
        earliest_next = earliest_reg;
        scan_next     = scan_reg;
        keep_next     = keep_reg;
        wcnt_next     = wcnt_reg;
        ptr_next      = ptr_reg;

        if (capture)
        begin
            scan_next = '0;
            keep_next = '0;
            wcnt_next = '0;
            ptr_next  = '0;
            if (item.mode == swt_pkg::MODE_TICK)
            begin
                earliest_next = swt_pkg::TICK_MAX;
            end
        end
        if (cmd.sleep_do && !full)
        begin
            count_next    = CW'(count_reg + CNT_ONE);
            earliest_next = sleep_min;
        end
        if (cmd.scan_step)
        begin
            scan_next = CW'(scan_reg + CNT_ONE);
            if (wake_hit)
            begin
                wcnt_next = CW'(wcnt_reg + CNT_ONE);
            end
            else
            begin
                keep_next = CW'(keep_reg + CNT_ONE);
                if (entry_tick < earliest_reg)
                begin
                    earliest_next = entry_tick;
                end
            end
        end
        if (cmd.finish)
        begin
            count_next = keep_reg;
        end
        if (cmd.emit_step)
        begin
            ptr_next = CW'(ptr_reg + CNT_ONE);
        end
    end

    always_comb
    begin
        if (cmd.sleep_do || cmd.load_none || cmd.emit_step)
        begin
            out_valid_next = 1'b1;
        end
        else
        begin
            out_valid_next = out_valid_reg && !result.ready;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            count_reg     <= '0;
            earliest_reg  <= swt_pkg::TICK_MAX;
            scan_reg      <= '0;
            keep_reg      <= '0;
            wcnt_reg      <= '0;
            ptr_reg       <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            count_reg     <= count_next;
            earliest_reg  <= earliest_next;
            scan_reg      <= scan_next;
            keep_reg      <= keep_next;
            wcnt_reg      <= wcnt_next;
            ptr_reg       <= ptr_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        if (capture)
        begin
            mode_reg <= item.mode;
            id_reg   <= item.thread_id;
            tick_reg <= item.tick_value;
        end
        if (cmd.sleep_do)
        begin
            out_status_reg <= full ? swt_pkg::STATUS_FULL : swt_pkg::STATUS_ACCEPTED;
            out_id_reg     <= '0;
            out_next_reg   <= sleep_min;
            out_last_reg   <= 1'b1;
        end
        else if (cmd.load_none)
        begin
            out_status_reg <= swt_pkg::STATUS_NONE;
            out_id_reg     <= '0;
            out_next_reg   <= earliest_reg;
            out_last_reg   <= 1'b1;
        end
        else if (cmd.emit_step)
        begin
            out_status_reg <= swt_pkg::STATUS_WOKEN;
            out_id_reg     <= wk_rdata;
            out_next_reg   <= earliest_reg;
            out_last_reg   <= emit_last;
        end
    end

    assign result.valid       = out_valid_reg;
    assign result.status      = out_status_reg;
    assign result.woken_id    = out_id_reg;
    assign result.next_wakeup = out_next_reg;
    assign result.last        = out_last_reg;

    // Read address follows the next index, so read data lines up with the
    // current index. Compaction writes land at or below the index in work.
    assign tbl_raddr = (scan_next == CNT_FULL) ? '0 : scan_next[AW-1:0];
    assign wk_raddr  = (ptr_next == CNT_FULL) ? '0 : ptr_next[AW-1:0];

    assign tbl_we    = (cmd.sleep_do && !full && !mode_reg) || (cmd.scan_step && !wake_hit);
    assign tbl_waddr = cmd.sleep_do ? count_reg[AW-1:0] : keep_reg[AW-1:0];
    assign tbl_wdata = cmd.sleep_do ? {tick_reg, id_reg} : tbl_rdata;

    assign wk_we     = cmd.scan_step && wake_hit;

    swt_ram #(
        .WIDTH (EW),
        .DEPTH (DEPTH)
    ) u_table (
        .clk   (clk),
        .we    (tbl_we),
        .waddr (tbl_waddr),
        .wdata (tbl_wdata),
        .raddr (tbl_raddr),
        .rdata (tbl_rdata)
    );

    swt_ram #(
        .WIDTH (ID_W),
        .DEPTH (DEPTH)
    ) u_woken (
        .clk   (clk),
        .we    (wk_we),
        .waddr (wcnt_reg[AW-1:0]),
        .wdata (entry_id),
        .raddr (wk_raddr),
        .rdata (wk_rdata)
    );

endmodule
